// ===== sv/tspr_pkg.sv =====
// ----------------------------------------------------------------------------
// tspr_pkg: shared types and constants
// Function codes, store sizes and the queue entry type for the pixel renderer.
// ----------------------------------------------------------------------------
`default_nettype none
package tspr_pkg;

    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 192;
    localparam int TABLE_COLS    = 32;
    localparam int TABLE_ROWS    = 32;
    localparam int SPRITE_COUNT  = 64;

    localparam logic [2:0] FUNC_NT    = 3'd0;
    localparam logic [2:0] FUNC_SPT   = 3'd1;
    localparam logic [2:0] FUNC_BGT   = 3'd2;
    localparam logic [2:0] FUNC_ATTR  = 3'd3;
    localparam logic [2:0] FUNC_QUERY = 3'd4;

    localparam logic [2:0] REG_BACK   = 3'd0;
    localparam logic [2:0] REG_SCRX   = 3'd1;
    localparam logic [2:0] REG_SCRY   = 3'd2;
    localparam logic [2:0] REG_BGON   = 3'd3;
    localparam logic [2:0] REG_NT1ON  = 3'd4;
    localparam logic [2:0] REG_SPRON  = 3'd5;

    localparam int SPR_IDX_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int QDEPTH    = 4;

    // One classified item in the queue between front and back.
    typedef struct packed {
        logic [2:0]  func;
        logic [13:0] addr;
        logic [7:0]  data;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        off_screen;
    } tspr_cmd_t;

endpackage
`default_nettype wire

// ===== sv/tspr_front.sv =====
// ----------------------------------------------------------------------------
// tspr_front: input acceptance and command queue
// Accepts items, drops unused function codes, flags off-screen queries and
// holds up to four commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module tspr_front
    import tspr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [40:0] s_tdata,
    output logic            q_valid,
    output tspr_cmd_t       q_cmd,
    input  wire logic       q_pop
);
    localparam int PW = $clog2(QDEPTH);

    tspr_cmd_t      mem_reg [QDEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [PW:0]    cnt_reg, cnt_next;
    tspr_cmd_t      c;
    logic           push, pop, keep;

    always_comb
    begin
        c.func = s_tdata[2:0];
        c.addr = s_tdata[16:3];
        c.data = s_tdata[24:17];
        c.x    = s_tdata[32:25];
        c.y    = s_tdata[40:33];
        c.off_screen = ({1'b0, c.x} >= 9'(SCREEN_WIDTH)) ||
                       ({1'b0, c.y} >= 9'(SCREEN_HEIGHT));
    end

    assign s_tready = (cnt_reg != (PW+1)'(QDEPTH));
    assign keep     = (c.func <= FUNC_QUERY);
    assign push     = s_tvalid && s_tready && keep;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/tspr_back.sv =====
// ----------------------------------------------------------------------------
// tspr_back: store writes and pixel shading sequencer
// Owns the four byte stores; a query fetches the background pixel when that
// layer is on, then walks the sprite table sprite by sprite when sprites are on.
// ----------------------------------------------------------------------------
`default_nettype none
module tspr_back
    import tspr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire tspr_cmd_t  q_cmd,
    output logic            q_pop,
    input  wire logic [7:0] back_color,
    input  wire logic [8:0] scroll_horiz,
    input  wire logic [7:0] scroll_vert,
    input  wire logic       background_on,
    input  wire logic       second_table_on,
    input  wire logic       sprites_on,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_NT   = 4'd1;
    localparam logic [3:0] ST_BG   = 4'd2;
    localparam logic [3:0] ST_BGW  = 4'd3;
    localparam logic [3:0] ST_A0   = 4'd4;
    localparam logic [3:0] ST_A1   = 4'd5;
    localparam logic [3:0] ST_A2   = 4'd6;
    localparam logic [3:0] ST_A3   = 4'd7;
    localparam logic [3:0] ST_SAT  = 4'd8;
    localparam logic [3:0] ST_SPW  = 4'd9;
    localparam logic [3:0] ST_SPA  = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    logic [7:0] nt_mem  [2048];
    logic [7:0] spt_mem [16384];
    logic [7:0] bgt_mem [16384];
    logic [7:0] at_mem  [256];

    logic [3:0]  st_reg;
    logic [7:0]  col_reg, x_reg, y_reg;
    logic [9:0]  wx_reg;
    logic [8:0]  wy_reg;
    logic        nt_ok_reg;
    logic [SPR_IDX_W-1:0] spr_reg;
    logic [7:0]  tile_reg, attr_reg, sx_reg;
    logic        hit_reg;
    logic [2:0]  dx_reg, dy_reg;
    logic [7:0]  nt_q, bgt_q, spt_q, at_q;
    logic        out_v_reg;
    logic [7:0]  out_reg;

    logic [10:0] nt_ra;
    logic [13:0] bg_ra, sp_ra;
    logic [7:0]  at_ra;
    logic [9:0]  wx_c;
    logic [8:0]  wy_c;
    logic [6:0]  tcol;
    logic [1:0]  ac;
    logic        wr;
    logic [8:0]  ddx, ddy;

    assign wx_c  = {2'b0, q_cmd.x} + {1'b0, scroll_horiz};
    assign wy_c  = {1'b0, q_cmd.y} + {1'b0, scroll_vert};
    assign tcol  = wx_reg[9:3];
    assign nt_ra = 11'(((tcol >= 7'(TABLE_COLS)) ? TABLE_COLS*TABLE_ROWS : 0)
                 + (int'(wy_reg[8:3]) % TABLE_ROWS) * TABLE_COLS
                 + int'(tcol) % TABLE_COLS);
    // A tile is 64 bytes, so the full tile number sits above row and column.
    assign bg_ra = {nt_q, wy_reg[2:0], wx_reg[2:0]};
    assign sp_ra = {tile_reg, dy_reg, dx_reg};

    always_comb
    begin
        case (st_reg)
            ST_A0:   ac = 2'd0;
            ST_A1:   ac = 2'd1;
            ST_A2:   ac = 2'd2;
            default: ac = 2'd3;
        endcase
    end
    assign at_ra = 8'({spr_reg, ac});

    assign wr    = (st_reg == ST_IDLE) && q_valid && (q_cmd.func != FUNC_QUERY);
    assign q_pop = (st_reg == ST_IDLE) && q_valid &&
                   ((q_cmd.func != FUNC_QUERY) || !out_v_reg);
    assign ddx   = {1'b0, x_reg} - {1'b0, sx_reg};
    assign ddy   = {1'b0, y_reg} - {1'b0, at_q};
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr && q_cmd.func == FUNC_NT)   nt_mem[q_cmd.addr[10:0]] <= q_cmd.data;
        if (wr && q_cmd.func == FUNC_SPT)  spt_mem[q_cmd.addr]      <= q_cmd.data;
        if (wr && q_cmd.func == FUNC_BGT)  bgt_mem[q_cmd.addr]      <= q_cmd.data;
        if (wr && q_cmd.func == FUNC_ATTR) at_mem[q_cmd.addr[7:0]]  <= q_cmd.data;
        nt_q  <= nt_mem[nt_ra];
        bgt_q <= bgt_mem[bg_ra];
        spt_q <= spt_mem[sp_ra];
        at_q  <= at_mem[at_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            out_v_reg <= 1'b0;
            out_reg   <= '0;
            col_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            wx_reg    <= '0;
            wy_reg    <= '0;
            nt_ok_reg <= 1'b0;
            spr_reg   <= '0;
            tile_reg  <= '0;
            attr_reg  <= '0;
            sx_reg    <= '0;
            hit_reg   <= 1'b0;
            dx_reg    <= '0;
            dy_reg    <= '0;
        end
        else
        begin
            if (st_reg == ST_OUT)
                out_v_reg <= 1'b1;
            else if (out_v_reg && m_tready)
                out_v_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                    if (q_pop && q_cmd.func == FUNC_QUERY)
                    begin
                        col_reg <= back_color;
                        x_reg   <= q_cmd.x;
                        y_reg   <= q_cmd.y;
                        wx_reg  <= wx_c;
                        wy_reg  <= wy_c;
                        spr_reg <= '0;
                        if (q_cmd.off_screen)
                            st_reg <= ST_OUT;
                        else if (background_on)
                            st_reg <= ST_NT;
                        else if (sprites_on)
                            st_reg <= ST_A0;
                        else
                            st_reg <= ST_OUT;
                    end
                ST_NT:
                begin
                    nt_ok_reg <= (tcol < 7'(TABLE_COLS)) || second_table_on;
                    st_reg    <= ST_BG;
                end
                ST_BG:
                    st_reg <= ST_BGW;
                ST_BGW:
                begin
                    if (nt_ok_reg && bgt_q != 8'd0)
                        col_reg <= bgt_q + 8'd3;
                    st_reg <= sprites_on ? ST_A0 : ST_OUT;
                end
                ST_A0:
                    st_reg <= ST_A1;
                ST_A1:
                begin
                    tile_reg <= at_q;
                    st_reg   <= ST_A2;
                end
                ST_A2:
                begin
                    attr_reg <= at_q;
                    st_reg   <= ST_A3;
                end
                ST_A3:
                begin
                    sx_reg <= at_q;
                    st_reg <= ST_SAT;
                end
                ST_SAT:
                begin
                    hit_reg <= !attr_reg[2] && !ddx[8] && !ddy[8] &&
                               (ddx[7:3] == 5'd0) && (ddy[7:3] == 5'd0);
                    dx_reg  <= attr_reg[0] ? ~ddx[2:0] : ddx[2:0];
                    dy_reg  <= attr_reg[1] ? ~ddy[2:0] : ddy[2:0];
                    st_reg  <= ST_SPW;
                end
                ST_SPW:
                    st_reg <= ST_SPA;
                ST_SPA:
                begin
                    // Later sprites overwrite earlier ones.
                    if (hit_reg && spt_q != 8'd0)
                        col_reg <= spt_q;
                    if (spr_reg == SPR_IDX_W'(SPRITE_COUNT - 1))
                        st_reg <= ST_OUT;
                    else
                    begin
                        spr_reg <= spr_reg + 1'b1;
                        st_reg  <= ST_A0;
                    end
                end
                ST_OUT:
                begin
                    out_reg <= col_reg;
                    st_reg  <= ST_IDLE;
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/tile_sprite_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// tile_sprite_pixel_renderer: tile and sprite pixel generator
// Top level: APB register file, front queue and back-end shading sequencer.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_*       in   items: func, store_addr, store_data, pixel_x, pixel_y
// m_*       out  results: color of a queried pixel
// APB       in   back_color, scroll, layer enables
//
// A store write is done by the back end while it is idle. A query leaves
// the queue, runs the background fetch when that layer is on, then for each
// sprite when sprites are on four single-byte attribute reads, a compare, a
// tile read and the update, and finally loads the result; an off-screen
// pixel goes straight from the queue to loading the result.
// Reset clears control and registers; stores are undefined until written.
// The front queue holds up to four items while the back end is busy; a query
// leaves it only once the previous color has been taken.
// ----------------------------------------------------------------------------
`default_nettype none
module tile_sprite_pixel_renderer
    import tspr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // func, store_addr, store_data, pixel_x, pixel_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // color
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [7:0] back_color_reg;
    logic [8:0] scroll_horiz_reg;
    logic [7:0] scroll_vert_reg;
    logic       background_on_reg, second_table_on_reg, sprites_on_reg;
    logic       q_valid, q_pop;
    tspr_cmd_t  q_cmd;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_color_reg      <= '0;
            scroll_horiz_reg    <= '0;
            scroll_vert_reg     <= '0;
            background_on_reg   <= 1'b0;
            second_table_on_reg <= 1'b0;
            sprites_on_reg      <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_BACK:  back_color_reg      <= pwdata[7:0];
                REG_SCRX:  scroll_horiz_reg    <= pwdata[8:0];
                REG_SCRY:  scroll_vert_reg     <= pwdata[7:0];
                REG_BGON:  background_on_reg   <= pwdata[0];
                REG_NT1ON: second_table_on_reg <= pwdata[0];
                REG_SPRON: sprites_on_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_BACK:  prdata = {24'd0, back_color_reg};
            REG_SCRX:  prdata = {23'd0, scroll_horiz_reg};
            REG_SCRY:  prdata = {24'd0, scroll_vert_reg};
            REG_BGON:  prdata = {31'd0, background_on_reg};
            REG_NT1ON: prdata = {31'd0, second_table_on_reg};
            REG_SPRON: prdata = {31'd0, sprites_on_reg};
            default:   prdata = '0;
        endcase
    end

    tspr_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata[40:0]),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    tspr_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .back_color(back_color_reg), .scroll_horiz(scroll_horiz_reg),
        .scroll_vert(scroll_vert_reg), .background_on(background_on_reg),
        .second_table_on(second_table_on_reg), .sprites_on(sprites_on_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule
`default_nettype wire
